### sv/pfrt_pkg.sv
// Shared types and constants of the pitchfork ring tether evaluator.
// No dependencies; every other file imports this package.
`default_nettype none

package pfrt_pkg;

    localparam int DATA_W     = 32;
    localparam int ROOT_W     = 64;
    localparam int SQRT_STEPS = ROOT_W / 2;
    localparam int DIV_STEPS  = DATA_W;
    localparam int MUL_STAGES = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MU     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

    localparam logic [30:0] RADIUS_RESET = 31'd65536;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
    } pos_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] energy_out;
        logic signed [DATA_W-1:0] force_x;
        logic signed [DATA_W-1:0] force_y;
        logic signed [DATA_W-1:0] force_z;
        logic                     on_axis;
        logic                     saturated;
    } res_t;

endpackage

`default_nettype wire

### sv/pfrt_if.sv
// Valid/ready channels for position requests and result requests.
// Depends on pfrt_pkg for the payload types.
`default_nettype none

interface pfrt_pos_if import pfrt_pkg::*; ();
    logic valid;
    logic ready;
    pos_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pfrt_res_if import pfrt_pkg::*; ();
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/pfrt_sqrt_cell.sv
// One step of the pipelined integer square root: settle one result bit.
// Depends on pfrt_pkg for the root width.
`default_nettype none

module pfrt_sqrt_cell import pfrt_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [ROOT_W-1:0] rem_in,
    input  wire logic [ROOT_W-1:0] root_in,
    output logic      [ROOT_W-1:0] rem_out,
    output logic      [ROOT_W-1:0] root_out
);

    localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (ROOT_W - 2 - 2 * STEP);

    logic [ROOT_W-1:0] trial;
    logic              fits;
    logic [ROOT_W-1:0] rem_next;
    logic [ROOT_W-1:0] root_next;
    logic [ROOT_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;

    always_comb
    begin
        trial     = root_in + BIT;
        fits      = rem_in >= trial;
        rem_next  = fits ? rem_in - trial : rem_in;
        root_next = fits ? (root_in >> 1) + BIT : root_in >> 1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

`default_nettype wire

### sv/pfrt_div_cell.sv
// One step of the pipelined restoring divider: shift in one dividend bit,
// subtract the divisor where it fits, emit one quotient bit. Uses pfrt_pkg.
`default_nettype none

module pfrt_div_cell import pfrt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [DATA_W-1:0] rem_in,
    input  wire logic [DATA_W-1:0] low_in,
    input  wire logic [DATA_W-1:0] quo_in,
    input  wire logic [DATA_W-1:0] dvs_in,
    output logic      [DATA_W-1:0] rem_out,
    output logic      [DATA_W-1:0] low_out,
    output logic      [DATA_W-1:0] quo_out,
    output logic      [DATA_W-1:0] dvs_out
);

    logic [DATA_W:0]   shifted;
    logic              fits;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] rem_next;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] low_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;

    always_comb
    begin
        shifted  = {rem_in, low_in[DATA_W-1]};
        diff     = shifted - {1'b0, dvs_in};
        fits     = shifted >= {1'b0, dvs_in};
        rem_next = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_in[DATA_W-2:0], 1'b0};
            quo_reg <= {quo_in[DATA_W-2:0], fits};
            dvs_reg <= dvs_in;
        end
    end

    assign rem_out = rem_reg;
    assign low_out = low_reg;
    assign quo_out = quo_reg;
    assign dvs_out = dvs_reg;

endmodule

`default_nettype wire

### sv/pfrt_mul.sv
// Two-stage unsigned 64 x 64 multiplier built from four 32 x 32 partials.
// Depends on pfrt_pkg for the word width.
`default_nettype none

module pfrt_mul import pfrt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [2*DATA_W-1:0] a,
    input  wire logic [2*DATA_W-1:0] b,
    output logic      [4*DATA_W-1:0] prod
);

    logic [2*DATA_W-1:0] ll_reg;
    logic [2*DATA_W-1:0] lh_reg;
    logic [2*DATA_W-1:0] hl_reg;
    logic [2*DATA_W-1:0] hh_reg;
    logic [4*DATA_W-1:0] prod_next;
    logic [4*DATA_W-1:0] prod_reg;

    always_comb
    begin
        prod_next = (4*DATA_W)'(ll_reg)
                  + ((4*DATA_W)'(lh_reg) << DATA_W)
                  + ((4*DATA_W)'(hl_reg) << DATA_W)
                  + ((4*DATA_W)'(hh_reg) << (2*DATA_W));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg   <= (2*DATA_W)'(a[DATA_W-1:0]) * (2*DATA_W)'(b[DATA_W-1:0]);
            lh_reg   <= (2*DATA_W)'(a[DATA_W-1:0]) * (2*DATA_W)'(b[2*DATA_W-1:DATA_W]);
            hl_reg   <= (2*DATA_W)'(a[2*DATA_W-1:DATA_W]) * (2*DATA_W)'(b[DATA_W-1:0]);
            hh_reg   <= (2*DATA_W)'(a[2*DATA_W-1:DATA_W]) * (2*DATA_W)'(b[2*DATA_W-1:DATA_W]);
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### sv/pitchfork_ring_tether_eval.sv
// Pitchfork ring tether evaluator, top level.
// Depends on pfrt_pkg, pfrt_if, pfrt_sqrt_cell, pfrt_div_cell and pfrt_mul.
//
// Usage:
//   position (sink) takes one request per cycle holding pos_x, pos_y, pos_z
//   in signed fixed point with FRAC_BITS fraction bits. result (source)
//   returns one request per position: energy, force vector, on_axis and
//   saturated. The configuration port writes mu, alpha and the orbit radius
//   by index; write it only while no request is in flight.
//   The pipeline has 79 register stages, the first loaded at the accepting
//   edge. Throughput is one position per cycle while results are taken,
//   set by a fully pipelined datapath: a 32-cell square root chain,
//   two 32-cell divider chains (one per transverse force) and two-stage
//   split multipliers.
//   A stalled result holds the whole pipeline in place; position.ready drops
//   only while the final stage holds a result that is not taken. Bubbles
//   inside the pipeline stay where they are and are not squeezed out.
//   Reset clears every stage valid bit and loads mu = 0, alpha = 0 and
//   radius = 65536; no result is pending after reset.
`default_nettype none

module pitchfork_ring_tether_eval import pfrt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    pfrt_pos_if.sink                  position,
    pfrt_res_if.source                result
);

    localparam int LATENCY = 3 + SQRT_STEPS + 4 + MUL_STAGES + 2 + MUL_STAGES + 1
                           + DIV_STEPS + 1;

    // Sideband bundles that ride alongside the chains.
    typedef struct packed {
        logic signed [DATA_W-1:0]   x;
        logic signed [DATA_W-1:0]   y;
        logic signed [DATA_W-1:0]   z;
        logic signed [2*DATA_W-1:0] az;
    } root_sb_t;

    typedef struct packed {
        logic [DATA_W-1:0]          p;
        logic                       dneg;
        logic [DATA_W-1:0]          magd;
        logic signed [DATA_W-1:0]   x;
        logic signed [DATA_W-1:0]   y;
        logic signed [DATA_W-1:0]   z;
        logic signed [2*DATA_W-1:0] az;
    } rad_sb_t;

    typedef struct packed {
        logic [DATA_W-1:0]          p;
        logic signed [DATA_W-1:0]   x;
        logic signed [DATA_W-1:0]   y;
        logic signed [2*DATA_W-1:0] az;
        logic                       sg2;
        logic                       sg3;
        logic                       sg4;
    } fit_sb_t;

    typedef struct packed {
        logic [DATA_W-1:0] energy;
        logic              esat;
        logic [DATA_W-1:0] fz;
        logic              zsat;
        logic              sx;
        logic              sy;
        logic [DATA_W-1:0] p;
    } frc_sb_t;

    typedef struct packed {
        logic [DATA_W-1:0] energy;
        logic              esat;
        logic [DATA_W-1:0] fz;
        logic              zsat;
        logic              sx;
        logic              sy;
        logic              ovfx;
        logic              ovfy;
        logic              axis;
    } div_sb_t;

    function automatic logic [DATA_W:0] sat32(input logic signed [4*DATA_W-1:0] v);
        logic [DATA_W:0] r;
        if ((&v[4*DATA_W-1:DATA_W-1]) || !(|v[4*DATA_W-1:DATA_W-1]))
            r = {1'b0, v[DATA_W-1:0]};
        else
            r = {1'b1, v[4*DATA_W-1] ? SAT_MIN : SAT_MAX};
        return r;
    endfunction

    function automatic logic [DATA_W:0] side_sat(input logic [DATA_W-1:0] q,
                                                 input logic neg,
                                                 input logic ovf,
                                                 input logic axis);
        logic [DATA_W:0] r;
        priority if (axis)
            r = '0;
        else if (ovf)
            r = {1'b1, neg ? SAT_MIN : SAT_MAX};
        else if (neg)
            r = (q > SAT_MIN) ? {1'b1, SAT_MIN} : {1'b0, ~q + 32'd1};
        else
            r = (q > SAT_MAX) ? {1'b1, SAT_MAX} : {1'b0, q};
        return r;
    endfunction

    // Configuration registers and pipeline control.
    logic signed [DATA_W-1:0] mu_reg;
    logic signed [DATA_W-1:0] alpha_reg;
    logic [30:0]              radius_reg;
    logic [LATENCY-1:0]       vld_reg;
    logic                     en;

    assign en             = !vld_reg[LATENCY-1] || result.ready;
    assign position.ready = en;
    assign result.valid   = vld_reg[LATENCY-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg     <= '0;
            alpha_reg  <= '0;
            radius_reg <= RADIUS_RESET;
            vld_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MU:     mu_reg     <= cfg_data;
                    CFG_ALPHA:  alpha_reg  <= cfg_data;
                    CFG_RADIUS: radius_reg <= cfg_data[30:0];
                    default:    ;
                endcase
            end
            if (en)
                vld_reg <= {vld_reg[LATENCY-2:0], position.valid};
        end
    end

    // Front: squares of x and y, alpha*z, then radius squared and az.
    logic signed [DATA_W-1:0]   x1_reg, y1_reg, z1_reg;
    logic [2*DATA_W-1:0]        ax2_reg, ay2_reg;
    logic signed [2*DATA_W-1:0] azp_reg;
    root_sb_t                   sb2_reg, sb3_reg;
    logic [ROOT_W-1:0]          rad_reg;
    logic [DATA_W-1:0]          mx1, my1;

    always_comb
    begin
        mx1 = x1_reg[DATA_W-1] ? DATA_W'(-x1_reg) : DATA_W'(x1_reg);
        my1 = y1_reg[DATA_W-1] ? DATA_W'(-y1_reg) : DATA_W'(y1_reg);
    end

    // Square root chain.
    logic [ROOT_W-1:0] root_rem [0:SQRT_STEPS];
    logic [ROOT_W-1:0] root_val [0:SQRT_STEPS];
    root_sb_t          root_sb_reg [0:SQRT_STEPS-1];

    assign root_rem[0] = rad_reg;
    assign root_val[0] = '0;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_root
        pfrt_sqrt_cell #(.STEP(k)) u_cell (
            .clk      (clk),
            .en       (en),
            .rem_in   (root_rem[k]),
            .root_in  (root_val[k]),
            .rem_out  (root_rem[k+1]),
            .root_out (root_val[k+1])
        );
    end

    // Radial offset d, its square and d2.
    logic [DATA_W-1:0]       p_now;
    logic signed [DATA_W+1:0] d_now;
    logic [DATA_W+1:0]       magd_now;
    rad_sb_t                 rad4_next, rad4_reg, rad5_reg, rad6_reg;
    logic [2*DATA_W-1:0]     sq5_reg, d2_6_reg;

    always_comb
    begin
        p_now    = root_val[SQRT_STEPS][DATA_W-1:0];
        d_now    = $signed({2'b00, p_now}) - $signed({3'b000, radius_reg});
        magd_now = d_now[DATA_W+1] ? (DATA_W+2)'(-d_now) : (DATA_W+2)'(d_now);
        rad4_next.p    = p_now;
        rad4_next.dneg = d_now[DATA_W+1];
        rad4_next.magd = magd_now[DATA_W-1:0];
        rad4_next.x    = root_sb_reg[SQRT_STEPS-1].x;
        rad4_next.y    = root_sb_reg[SQRT_STEPS-1].y;
        rad4_next.z    = root_sb_reg[SQRT_STEPS-1].z;
        rad4_next.az   = root_sb_reg[SQRT_STEPS-1].az;
    end

    // Magnitudes and signs of the four energy / radial force products.
    logic signed [2*DATA_W:0] t6;
    logic [2*DATA_W-1:0]      magt6, magmu6, magaz6, magz6;
    fit_sb_t                  fit7_next, fit7_reg;
    logic [2*DATA_W-1:0]      d2_7_reg, magmu7_reg, magt7_reg, magd7_reg;
    logic [2*DATA_W-1:0]      magaz7_reg, magz7_reg;
    fit_sb_t                  fit_sb_reg [0:MUL_STAGES-1];

    always_comb
    begin
        t6     = (2*DATA_W+1)'(mu_reg) - $signed({1'b0, d2_6_reg});
        magt6  = t6[2*DATA_W] ? (2*DATA_W)'(-t6) : (2*DATA_W)'(t6);
        magmu6 = mu_reg[DATA_W-1] ? (2*DATA_W)'(-(2*DATA_W)'(mu_reg))
                                  : (2*DATA_W)'(mu_reg);
        magaz6 = rad6_reg.az[2*DATA_W-1] ? (2*DATA_W)'(-rad6_reg.az)
                                         : (2*DATA_W)'(rad6_reg.az);
        magz6  = rad6_reg.z[DATA_W-1] ? (2*DATA_W)'(-(2*DATA_W)'(rad6_reg.z))
                                      : (2*DATA_W)'(rad6_reg.z);
        fit7_next.p   = rad6_reg.p;
        fit7_next.x   = rad6_reg.x;
        fit7_next.y   = rad6_reg.y;
        fit7_next.az  = rad6_reg.az;
        fit7_next.sg2 = mu_reg[DATA_W-1];
        fit7_next.sg3 = t6[2*DATA_W] ^ rad6_reg.dneg;
        fit7_next.sg4 = rad6_reg.az[2*DATA_W-1] ^ rad6_reg.z[DATA_W-1];
    end

    logic [4*DATA_W-1:0] prod1, prod2, prod3, prod4;

    pfrt_mul u_mul_d4 (.clk(clk), .en(en), .a(d2_7_reg),   .b(d2_7_reg),  .prod(prod1));
    pfrt_mul u_mul_mu (.clk(clk), .en(en), .a(magmu7_reg), .b(d2_7_reg),  .prod(prod2));
    pfrt_mul u_mul_fr (.clk(clk), .en(en), .a(magt7_reg),  .b(magd7_reg), .prod(prod3));
    pfrt_mul u_mul_az (.clk(clk), .en(en), .a(magaz7_reg), .b(magz7_reg), .prod(prod4));

    // Combine: energy sum before scaling and the clipped radial force.
    logic [4*DATA_W-1:0]        p2s, p3s, p4s, s8_next;
    logic signed [4*DATA_W-1:0] fr_full;
    logic signed [2*DATA_W-1:0] fr8_next;
    fit_sb_t                    fit_last;
    logic [4*DATA_W-1:0]        s8_reg;
    logic signed [2*DATA_W-1:0] fr8_reg;
    fit_sb_t                    fit8_reg;

    always_comb
    begin
        fit_last = fit_sb_reg[MUL_STAGES-1];
        p2s      = fit_last.sg2 ? -prod2 : prod2;
        p3s      = fit_last.sg3 ? -prod3 : prod3;
        p4s      = fit_last.sg4 ? -prod4 : prod4;
        s8_next  = prod1 - (p2s << 1) + (p4s << 1);
        fr_full  = $signed(p3s) >>> FRAC_BITS;
        if ((&fr_full[4*DATA_W-1:2*DATA_W-1]) || !(|fr_full[4*DATA_W-1:2*DATA_W-1]))
            fr8_next = fr_full[2*DATA_W-1:0];
        else
            fr8_next = fr_full[4*DATA_W-1] ? {1'b1, {(2*DATA_W-1){1'b0}}}
                                           : {1'b0, {(2*DATA_W-1){1'b1}}};
    end

    // Saturate energy and fz; form |fr|, |x|, |y| for the transverse forces.
    logic signed [4*DATA_W-1:0] e_full;
    logic signed [2*DATA_W:0]   nz;
    logic [DATA_W:0]            e_sat, z_sat;
    frc_sb_t                    frc9_next, frc9_reg;
    logic [2*DATA_W-1:0]        mfr9_next, mfr9_reg, mx9_reg, my9_reg;
    logic [DATA_W-1:0]          mx8, my8;
    frc_sb_t                    frc_sb_reg [0:MUL_STAGES-1];

    always_comb
    begin
        e_full = $signed(s8_reg) >>> (FRAC_BITS + 2);
        nz     = -$signed({fit8_reg.az[2*DATA_W-1], fit8_reg.az});
        e_sat  = sat32(e_full);
        z_sat  = sat32((4*DATA_W)'(nz));
        mfr9_next = fr8_reg[2*DATA_W-1] ? (2*DATA_W)'(-fr8_reg) : (2*DATA_W)'(fr8_reg);
        mx8 = fit8_reg.x[DATA_W-1] ? DATA_W'(-fit8_reg.x) : DATA_W'(fit8_reg.x);
        my8 = fit8_reg.y[DATA_W-1] ? DATA_W'(-fit8_reg.y) : DATA_W'(fit8_reg.y);
        frc9_next.energy = e_sat[DATA_W-1:0];
        frc9_next.esat   = e_sat[DATA_W];
        frc9_next.fz     = z_sat[DATA_W-1:0];
        frc9_next.zsat   = z_sat[DATA_W];
        frc9_next.sx     = fr8_reg[2*DATA_W-1] ^ fit8_reg.x[DATA_W-1];
        frc9_next.sy     = fr8_reg[2*DATA_W-1] ^ fit8_reg.y[DATA_W-1];
        frc9_next.p      = fit8_reg.p;
    end

    logic [4*DATA_W-1:0] nx_prod, ny_prod;

    pfrt_mul u_mul_fx (.clk(clk), .en(en), .a(mfr9_reg), .b(mx9_reg), .prod(nx_prod));
    pfrt_mul u_mul_fy (.clk(clk), .en(en), .a(mfr9_reg), .b(my9_reg), .prod(ny_prod));

    // Divider setup: a quotient of 2^32 or more saturates at once.
    div_sb_t           div10_next, div10_reg;
    logic [DATA_W-1:0] remx10_reg, lowx10_reg, remy10_reg, lowy10_reg, p10_reg;

    always_comb
    begin
        div10_next.energy = frc_sb_reg[MUL_STAGES-1].energy;
        div10_next.esat   = frc_sb_reg[MUL_STAGES-1].esat;
        div10_next.fz     = frc_sb_reg[MUL_STAGES-1].fz;
        div10_next.zsat   = frc_sb_reg[MUL_STAGES-1].zsat;
        div10_next.sx     = frc_sb_reg[MUL_STAGES-1].sx;
        div10_next.sy     = frc_sb_reg[MUL_STAGES-1].sy;
        div10_next.ovfx   = nx_prod[4*DATA_W-1:DATA_W] >=
                            (3*DATA_W)'(frc_sb_reg[MUL_STAGES-1].p);
        div10_next.ovfy   = ny_prod[4*DATA_W-1:DATA_W] >=
                            (3*DATA_W)'(frc_sb_reg[MUL_STAGES-1].p);
        div10_next.axis   = frc_sb_reg[MUL_STAGES-1].p == '0;
    end

    // Divider chains, one lane per transverse force.
    logic [DATA_W-1:0] dx_rem [0:DIV_STEPS];
    logic [DATA_W-1:0] dx_low [0:DIV_STEPS];
    logic [DATA_W-1:0] dx_quo [0:DIV_STEPS];
    logic [DATA_W-1:0] dx_dvs [0:DIV_STEPS];
    logic [DATA_W-1:0] dy_rem [0:DIV_STEPS];
    logic [DATA_W-1:0] dy_low [0:DIV_STEPS];
    logic [DATA_W-1:0] dy_quo [0:DIV_STEPS];
    logic [DATA_W-1:0] dy_dvs [0:DIV_STEPS];
    div_sb_t           div_sb_reg [0:DIV_STEPS-1];

    assign dx_rem[0] = remx10_reg;
    assign dx_low[0] = lowx10_reg;
    assign dx_quo[0] = '0;
    assign dx_dvs[0] = p10_reg;
    assign dy_rem[0] = remy10_reg;
    assign dy_low[0] = lowy10_reg;
    assign dy_quo[0] = '0;
    assign dy_dvs[0] = p10_reg;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        pfrt_div_cell u_cell_x (
            .clk     (clk),
            .en      (en),
            .rem_in  (dx_rem[k]),
            .low_in  (dx_low[k]),
            .quo_in  (dx_quo[k]),
            .dvs_in  (dx_dvs[k]),
            .rem_out (dx_rem[k+1]),
            .low_out (dx_low[k+1]),
            .quo_out (dx_quo[k+1]),
            .dvs_out (dx_dvs[k+1])
        );
        pfrt_div_cell u_cell_y (
            .clk     (clk),
            .en      (en),
            .rem_in  (dy_rem[k]),
            .low_in  (dy_low[k]),
            .quo_in  (dy_quo[k]),
            .dvs_in  (dy_dvs[k]),
            .rem_out (dy_rem[k+1]),
            .low_out (dy_low[k+1]),
            .quo_out (dy_quo[k+1]),
            .dvs_out (dy_dvs[k+1])
        );
    end

    // Final saturation of the transverse forces and the result register.
    div_sb_t         div_last;
    logic [DATA_W:0] fx_sat, fy_sat;
    res_t            res_next, res_reg;

    always_comb
    begin
        div_last = div_sb_reg[DIV_STEPS-1];
        fx_sat   = side_sat(dx_quo[DIV_STEPS], div_last.sx, div_last.ovfx, div_last.axis);
        fy_sat   = side_sat(dy_quo[DIV_STEPS], div_last.sy, div_last.ovfy, div_last.axis);
        res_next.energy_out = div_last.energy;
        res_next.force_x    = fx_sat[DATA_W-1:0];
        res_next.force_y    = fy_sat[DATA_W-1:0];
        res_next.force_z    = div_last.fz;
        res_next.on_axis    = div_last.axis;
        res_next.saturated  = div_last.esat | div_last.zsat | fx_sat[DATA_W] | fy_sat[DATA_W];
    end

    assign result.data = res_reg;

    // Payload registers: advance whenever the pipeline moves.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= position.data.pos_x;
            y1_reg  <= position.data.pos_y;
            z1_reg  <= position.data.pos_z;

            ax2_reg <= (2*DATA_W)'(mx1) * (2*DATA_W)'(mx1);
            ay2_reg <= (2*DATA_W)'(my1) * (2*DATA_W)'(my1);
            azp_reg <= (2*DATA_W)'(alpha_reg) * (2*DATA_W)'(z1_reg);
            sb2_reg <= '{x: x1_reg, y: y1_reg, z: z1_reg, az: '0};

            rad_reg    <= ax2_reg + ay2_reg;
            sb3_reg    <= '{x: sb2_reg.x, y: sb2_reg.y, z: sb2_reg.z,
                            az: azp_reg >>> FRAC_BITS};

            root_sb_reg[0] <= sb3_reg;
            for (int i = 1; i < SQRT_STEPS; i++)
                root_sb_reg[i] <= root_sb_reg[i-1];

            rad4_reg <= rad4_next;
            sq5_reg  <= (2*DATA_W)'(rad4_reg.magd) * (2*DATA_W)'(rad4_reg.magd);
            rad5_reg <= rad4_reg;
            d2_6_reg <= sq5_reg >> FRAC_BITS;
            rad6_reg <= rad5_reg;

            d2_7_reg   <= d2_6_reg;
            magmu7_reg <= magmu6;
            magt7_reg  <= magt6;
            magd7_reg  <= (2*DATA_W)'(rad6_reg.magd);
            magaz7_reg <= magaz6;
            magz7_reg  <= magz6;
            fit7_reg   <= fit7_next;

            fit_sb_reg[0] <= fit7_reg;
            for (int i = 1; i < MUL_STAGES; i++)
                fit_sb_reg[i] <= fit_sb_reg[i-1];

            s8_reg   <= s8_next;
            fr8_reg  <= fr8_next;
            fit8_reg <= fit_last;

            mfr9_reg <= mfr9_next;
            mx9_reg  <= (2*DATA_W)'(mx8);
            my9_reg  <= (2*DATA_W)'(my8);
            frc9_reg <= frc9_next;

            frc_sb_reg[0] <= frc9_reg;
            for (int i = 1; i < MUL_STAGES; i++)
                frc_sb_reg[i] <= frc_sb_reg[i-1];

            remx10_reg <= nx_prod[2*DATA_W-1:DATA_W];
            lowx10_reg <= nx_prod[DATA_W-1:0];
            remy10_reg <= ny_prod[2*DATA_W-1:DATA_W];
            lowy10_reg <= ny_prod[DATA_W-1:0];
            p10_reg    <= frc_sb_reg[MUL_STAGES-1].p;
            div10_reg  <= div10_next;

            div_sb_reg[0] <= div10_reg;
            for (int i = 1; i < DIV_STEPS; i++)
                div_sb_reg[i] <= div_sb_reg[i-1];

            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    // An on-axis result never carries transverse force.
    a_axis_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.on_axis |->
            result.data.force_x == '0 && result.data.force_y == '0)
        else $error("on-axis result with nonzero transverse force");

    // A held result stalls intake.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !position.ready)
        else $error("position accepted while result stalled");

    // An accepted position enters the first stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        position.valid && position.ready |=> vld_reg[0])
        else $error("accepted position lost at pipeline entry");
`endif

endmodule

`default_nettype wire

### dv/tb_pitchfork_ring_tether_eval.sv
// Self-checking bench for pitchfork_ring_tether_eval: drives position requests,
// predicts each tether energy and force result and checks every returned request.
// Depends on pfrt_pkg, pfrt_if and the evaluator RTL.
`timescale 1ns / 100ps

module tb_pitchfork_ring_tether_eval;
    import pfrt_pkg::*;

    localparam int FRAC = 16;
    // Index with no register behind it; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
    localparam int LONG_HOLD = 300;
    localparam int PIPE_LAT = 79;

    localparam logic signed [127:0] S64_MAX = (128'sd1 <<< 63) - 128'sd1;
    localparam logic signed [127:0] S64_MIN = -(128'sd1 <<< 63);
    localparam logic signed [127:0] S32_MAX = 128'sd2147483647;
    localparam logic signed [127:0] S32_MIN = -128'sd2147483648;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;

    pfrt_pos_if pos_ch ();
    pfrt_res_if res_ch ();

    pitchfork_ring_tether_eval #(.FRAC_BITS(FRAC)) i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .position  (pos_ch),
        .result    (res_ch)
    );

    // Shadow copy of the coefficient registers, updated with every write.
    logic signed [DATA_W-1:0] mu_shadow;
    logic signed [DATA_W-1:0] alpha_shadow;
    logic [30:0] radius_shadow;

    pos_t pending_pos[$];    // position requests not yet put on the bus
    res_t expected_res[$];   // predicted results, oldest first
    int n_offered;           // requests put on the bus by the driver
    int n_taken;             // requests accepted by the block
    int n_errors;
    bit gaps_on;
    bit stall_req;
    bit stall_done;
    int stall_cnt;
    int src_idle;
    int snk_idle;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Integer square root, floor, bit by bit.
    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] acc;
        logic [63:0] one;
        acc = '0;
        one = 64'd1 << 62;
        while (one > v)
            one = one >> 2;
        while (one != 0)
        begin
            if (v >= acc + one)
            begin
                v = v - (acc + one);
                acc = (acc >> 1) + one;
            end
            else
                acc = acc >> 1;
            one = one >> 2;
        end
        return acc;
    endfunction

    function automatic logic signed [DATA_W-1:0] clip32(logic signed [127:0] v, inout logic flag);
        if (v > S32_MAX)
        begin
            flag = 1'b1;
            return SAT_MAX;
        end
        if (v < S32_MIN)
        begin
            flag = 1'b1;
            return SAT_MIN;
        end
        return v[31:0];
    endfunction

    // Transverse force: radial force times coordinate over p, truncated to zero.
    function automatic logic signed [DATA_W-1:0] split_force(logic signed [127:0] fr,
        logic signed [127:0] c, logic [127:0] p, inout logic flag);
        logic [127:0] num;
        logic signed [127:0] q;
        num = (fr < 0 ? -fr : fr) * (c < 0 ? -c : c);
        q = num / p;
        if ((fr < 0) != (c < 0))
            q = -q;
        return clip32(q, flag);
    endfunction

    function automatic res_t tether_predict(pos_t pin);
        logic signed [127:0] x, y, z, mu, alpha, pr, d, d2, az, s, fr;
        logic [63:0] rsq;
        logic [63:0] p;
        logic sat;
        res_t r;
        x = pin.pos_x;
        y = pin.pos_y;
        z = pin.pos_z;
        mu = mu_shadow;
        alpha = alpha_shadow;
        sat = 1'b0;
        rsq = 64'(x * x + y * y);
        p = floor_root(rsq);
        pr = $signed({64'd0, p});
        d = pr - $signed({97'd0, radius_shadow});
        d2 = (d * d) >>> FRAC;
        az = (alpha * z) >>> FRAC;
        s = d2 * d2 - 128'sd2 * mu * d2 + 128'sd2 * az * z;
        r.energy_out = clip32(s >>> (FRAC + 2), sat);
        r.force_z = clip32(-az, sat);
        r.force_x = '0;
        r.force_y = '0;
        if (p != 0)
        begin
            fr = ((mu - d2) * d) >>> FRAC;
            if (fr > S64_MAX)
                fr = S64_MAX;
            else if (fr < S64_MIN)
                fr = S64_MIN;
            r.force_x = split_force(fr, x, {64'd0, p}, sat);
            r.force_y = split_force(fr, y, {64'd0, p}, sat);
        end
        r.on_axis = (p == 0);
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
        n_errors++;
    endtask

    // Write one register on a falling edge and mirror it in the shadow copy.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_MU: mu_shadow = val;
            CFG_ALPHA: alpha_shadow = val;
            CFG_RADIUS: radius_shadow = val[30:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_coeffs(logic [31:0] mu, logic [31:0] alpha, logic [31:0] radius);
        write_reg(CFG_MU, mu);
        write_reg(CFG_ALPHA, alpha);
        write_reg(CFG_RADIUS, radius);
        // a stray write to the unused index must leave everything alone
        write_reg(CFG_NONE, $urandom());
    endtask

    // Hold until every queued request has gone in and every result came back.
    task automatic wait_drained();
        while (pending_pos.size() != 0 || pos_ch.valid || expected_res.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord(logic [30:0] rad);
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return {1'b0, rad} + 32'($signed($urandom_range(0, 512)) - 256);
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 15)
                                           : 32'h8000_0000 + $urandom_range(0, 15);
            default: return 32'd0;
        endcase
    endfunction

    task automatic push_pos(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        pos_t item;
        item.pos_x = x;
        item.pos_y = y;
        item.pos_z = z;
        pending_pos.push_back(item);
    endtask

    task automatic push_random(int n);
        repeat (n)
            push_pos(rand_coord(radius_shadow), rand_coord(radius_shadow),
                     rand_coord(radius_shadow));
    endtask

    // Position driver: offer the next request once the previous one is taken.
    always @(negedge clk)
    begin
        if (!pos_ch.valid || n_taken == n_offered)
        begin
            if (gaps_on && src_idle > 0)
            begin
                src_idle--;
                pos_ch.valid <= 1'b0;
            end
            else if (pending_pos.size() != 0)
            begin
                pos_ch.data <= pending_pos.pop_front();
                pos_ch.valid <= 1'b1;
                n_offered++;
                if (gaps_on && $urandom_range(0, 7) == 0)
                    src_idle = $urandom_range(1, 15);
            end
            else
                pos_ch.valid <= 1'b0;
        end
    end

    // Result receiver: one long hold on request, otherwise random short bursts.
    always @(negedge clk)
    begin
        if (stall_req && !stall_done)
        begin
            res_ch.ready <= 1'b0;
            stall_cnt++;
            if (stall_cnt >= LONG_HOLD)
                stall_done = 1'b1;
        end
        else if (gaps_on && snk_idle > 0)
        begin
            res_ch.ready <= 1'b0;
            snk_idle--;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            if (gaps_on && $urandom_range(0, 9) == 0)
                snk_idle = $urandom_range(1, 15);
        end
    end

    // Predict on every accepted position request.
    always @(posedge clk)
    begin
        if (rst_n && pos_ch.valid && pos_ch.ready)
        begin
            expected_res.push_back(tether_predict(pos_ch.data));
            n_taken++;
        end
    end

    // Check every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        res_t want;
        res_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.data;
            if (expected_res.size() == 0)
            begin
                $display("unexpected result request at %0t", $time);
                n_errors++;
            end
            else
            begin
                want = expected_res.pop_front();
                if (got.energy_out !== want.energy_out)
                    report_mismatch("energy_out", got.energy_out, want.energy_out);
                if (got.force_x !== want.force_x)
                    report_mismatch("force_x", got.force_x, want.force_x);
                if (got.force_y !== want.force_y)
                    report_mismatch("force_y", got.force_y, want.force_y);
                if (got.force_z !== want.force_z)
                    report_mismatch("force_z", got.force_z, want.force_z);
                if (got.on_axis !== want.on_axis)
                    report_mismatch("on_axis", got.on_axis, want.on_axis);
                if (got.saturated !== want.saturated)
                    report_mismatch("saturated", got.saturated, want.saturated);
            end
        end
    end

    // Hard stop well past the slowest correct run.
    initial
    begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pos_ch.valid = 1'b0;
        pos_ch.data = '0;
        res_ch.ready = 1'b0;
        mu_shadow = '0;
        alpha_shadow = '0;
        radius_shadow = RADIUS_RESET;
        n_offered = 0;
        n_taken = 0;
        n_errors = 0;
        gaps_on = 1'b1;
        stall_req = 1'b0;
        stall_done = 1'b0;
        stall_cnt = 0;
        src_idle = 0;
        snk_idle = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset coefficients, on-axis, the ring itself, field extremes.
        push_pos(32'd0, 32'd0, 32'd0);
        push_pos(32'd0, 32'd0, 32'h7FFF_FFFF);
        push_pos(32'h0001_0000, 32'd0, 32'h8000_0000);
        push_pos(32'd0, 32'hFFFF_0000, 32'h0002_0000);
        push_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_pos(32'h8000_0000, 32'd0, 32'd1);
        push_pos(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();

        // Strong mu and alpha so the saturation flag fires on all fields.
        load_coeffs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_pos(32'd0, 32'd0, 32'h7FFF_FFFF);
        push_pos(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        push_pos(32'h0000_3000, 32'hFFFF_9000, 32'd0);
        push_pos(32'h4000_0000, 32'h4000_0000, 32'h0001_0000);
        wait_drained();
        load_coeffs(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        push_pos(32'd0, 32'd0, 32'd0);
        push_pos(32'd1, 32'd0, 32'h8000_0000);
        push_pos(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_pos(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_8000);
        wait_drained();

        // Moderate coefficients; hold the receiver off while requests keep coming.
        load_coeffs(32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
        stall_req = 1'b1;
        push_random(150);
        wait (stall_done);
        wait_drained();

        // Mid-phase pause: sender waits for every result before going on.
        load_coeffs(32'hFFFF_8000, 32'h0000_4000, 32'h0003_0000);
        push_random(70);
        wait_drained();
        push_random(70);
        wait_drained();

        load_coeffs(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
        push_random(120);
        wait_drained();

        repeat (2)
        begin
            load_coeffs($urandom(), $urandom(), $urandom());
            push_random(120);
            wait_drained();
        end

        // Last stretch at full rate with no idling on either side.
        load_coeffs(32'h0001_8000, 32'h0000_C000, 32'h0002_0000);
        gaps_on = 1'b0;
        push_random(150);
        wait_drained();

        repeat (PIPE_LAT + 20) @(posedge clk);
        if (n_errors == 0 && expected_res.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
